@@ design/fir_lowpass_filter_defines.svh @@
// ----------------------------------------------------------------------------
// FIR low-pass filter assertion macros
// Shared property forms. Every assertion is clocked on clk and is disabled
// while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef FIR_LOWPASS_FILTER_DEFINES_SVH
`define FIR_LOWPASS_FILTER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FIR_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fir_lowpass_filter: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define FIR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fir_lowpass_filter: next-cycle check failed");

`endif

@@ design/fir_pkg.sv @@
// ----------------------------------------------------------------------------
// FIR filter package
// Item and result types, the cell control bundle and shared constants.
// ----------------------------------------------------------------------------
package fir_pkg;

    localparam int TAPS_DEFAULT = 512;
    localparam int SAMPLE_W     = 16;
    localparam int COEFF_W      = 16;
    localparam int INDEX_W      = 9;
    localparam int FRAC_BITS    = 15;
    localparam int PROD_W       = SAMPLE_W + COEFF_W;
    // Number of tap positions that the index field can address.
    localparam int COEFF_SPAN   = 1 << INDEX_W;

    localparam logic MODE_SAMPLE = 1'b0;
    localparam logic MODE_COEFF  = 1'b1;

    typedef struct packed {
        logic                       mode;
        logic signed [SAMPLE_W-1:0] sample;
        logic        [INDEX_W-1:0]  coeff_index;
        logic signed [COEFF_W-1:0]  coeff_value;
    } fir_item_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] filtered;
        logic                       saturated;
    } fir_result_t;

    typedef struct packed {
        logic                      shift_en;
        logic                      mult_en;
        logic                      sum_en;
        logic                      coeff_we;
        logic [INDEX_W-1:0]        coeff_index;
        logic signed [COEFF_W-1:0] coeff_value;
    } fir_ctrl_t;

endpackage

@@ design/fir_cell.sv @@
// ----------------------------------------------------------------------------
// FIR tap cell
// Holds one delay-line sample and one coefficient, forms their product and
// adds it to the partial sum arriving from the previous cell.
// ----------------------------------------------------------------------------
module fir_cell #(
    parameter int ACC_W = fir_pkg::PROD_W + 9,
    parameter int IDX   = 0
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  fir_pkg::fir_ctrl_t                  ctrl,
    input  logic signed [fir_pkg::SAMPLE_W-1:0] x_in,
    output logic signed [fir_pkg::SAMPLE_W-1:0] x_out,
    input  logic signed [ACC_W-1:0]             sum_in,
    output logic signed [ACC_W-1:0]             sum_out
);

    localparam bit ADDRESSABLE = (IDX < fir_pkg::COEFF_SPAN);

    logic signed [fir_pkg::SAMPLE_W-1:0] x_reg, x_next;
    logic signed [fir_pkg::COEFF_W-1:0]  coeff_reg, coeff_next;
    logic signed [fir_pkg::PROD_W-1:0]   prod_reg, prod_next;
    logic signed [ACC_W-1:0]             sum_reg, sum_next;
    logic                                hit;

    assign hit = ADDRESSABLE && (ctrl.coeff_index == fir_pkg::INDEX_W'(IDX));

    always_comb
    begin
        x_next     = ctrl.shift_en ? x_in : x_reg;
        coeff_next = (ctrl.coeff_we && hit) ? ctrl.coeff_value : coeff_reg;
        prod_next  = ctrl.mult_en ? x_reg * coeff_reg : prod_reg;
        sum_next   = ctrl.sum_en ? sum_in + ACC_W'(prod_reg) : sum_reg;
    end

    // Delay-line sample and tap both start at zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_reg     <= '0;
            coeff_reg <= '0;
        end
        else
        begin
            x_reg     <= x_next;
            coeff_reg <= coeff_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        sum_reg  <= sum_next;
    end

    assign x_out   = x_reg;
    assign sum_out = sum_reg;

endmodule

@@ design/fir_out.sv @@
// ----------------------------------------------------------------------------
// FIR output stage
// Scales the final sum by 2^-15 with floor rounding, clips it to 16 bits
// and holds the result until the receiver takes it.
// ----------------------------------------------------------------------------
module fir_out #(
    parameter int ACC_W = fir_pkg::PROD_W + 9
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   load,
    input  logic signed [ACC_W-1:0] sum,
    output logic                   free,
    output logic                   result_valid,
    input  logic                   result_stall,
    output fir_pkg::fir_result_t   result
);

    localparam int Q_W = ACC_W - fir_pkg::FRAC_BITS;

    logic [Q_W-1:0]                       scaled;
    logic [Q_W-fir_pkg::SAMPLE_W:0]       upper;
    logic                                 in_range;
    fir_pkg::fir_result_t                 res_next;
    fir_pkg::fir_result_t                 res_reg;
    logic                                 valid_reg, valid_next;

    // Dropping the low bits of a two's complement value is a floor shift.
    assign scaled   = sum[ACC_W-1:fir_pkg::FRAC_BITS];
    assign upper    = scaled[Q_W-1:fir_pkg::SAMPLE_W-1];
    assign in_range = (&upper) || (~|upper);
    assign free     = !valid_reg || !result_stall;

    always_comb
    begin
        res_next.saturated = !in_range;
        if (in_range)
            res_next.filtered = scaled[fir_pkg::SAMPLE_W-1:0];
        else if (scaled[Q_W-1])
            res_next.filtered = {1'b1, {(fir_pkg::SAMPLE_W-1){1'b0}}};
        else
            res_next.filtered = {1'b0, {(fir_pkg::SAMPLE_W-1){1'b1}}};

        if (load)
            valid_next = 1'b1;
        else if (!result_stall)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            res_reg <= res_next;
    end

    assign result_valid = valid_reg;
    assign result       = res_reg;

endmodule

@@ design/fir_lowpass_filter.sv @@
// ----------------------------------------------------------------------------
// FIR low-pass filter
// Direct-form FIR built as a row of tap cells with run-time loadable taps.
// ----------------------------------------------------------------------------
// Usage:
// The item channel (item_valid, item_stall, item) carries either a sample
// or a coefficient load, selected by item.mode. A coefficient load writes
// one tap as it is accepted and gives no result; an index at or above TAPS
// is dropped. A sample transaction shifts the sample into the delay line and
// gives one result transaction on the result channel (result_valid,
// result_stall, result).
// After a sample is accepted, the cells form all products, the partial sum
// ripples down the row of cells, and the output stage scales and clips
// the final sum into the output register. The sample itself shifts in at
// the accepting edge. item_stall stays high until the result is loaded,
// so no further item is accepted before then; this wait covers the
// products, the ripple of the sum through the cell row and any output stall.
// Reset clears the delay line and all taps to zero and empties the output.
// While the receiver stalls, the result register holds its transaction; the
// next sample may still be accepted and finish its sum, and then waits until
// the output register is free.
// ----------------------------------------------------------------------------
`include "fir_lowpass_filter_defines.svh"

module fir_lowpass_filter #(
    parameter int TAPS = fir_pkg::TAPS_DEFAULT
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_stall,
    input  fir_pkg::fir_item_t   item,
    output logic                 result_valid,
    input  logic                 result_stall,
    output fir_pkg::fir_result_t result
);

    localparam int ACC_W = fir_pkg::PROD_W + $clog2(TAPS);
    localparam int CNT_W = (TAPS > 1) ? $clog2(TAPS) : 1;
    localparam logic [CNT_W-1:0] LAST = CNT_W'(TAPS - 1);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_MULT  = 4'b0010,
        ST_SUM   = 4'b0100,
        ST_DRAIN = 4'b1000
    } fir_state_t;

    fir_state_t                           state_reg, state_next;
    logic [CNT_W-1:0]                     cnt_reg, cnt_next;
    logic                                 accept;
    logic                                 out_free;
    logic                                 out_load;
    fir_pkg::fir_ctrl_t                   ctrl;
    logic signed [fir_pkg::SAMPLE_W-1:0]  x_chain [0:TAPS-1];
    logic signed [ACC_W-1:0]              sum_chain [0:TAPS];

    assign item_stall = (state_reg != ST_IDLE);
    assign accept     = item_valid && !item_stall;
    assign out_load   = (state_reg == ST_DRAIN) && out_free;

    always_comb
    begin
        ctrl.shift_en    = accept && (item.mode == fir_pkg::MODE_SAMPLE);
        ctrl.coeff_we    = accept && (item.mode == fir_pkg::MODE_COEFF);
        ctrl.mult_en     = (state_reg == ST_MULT);
        ctrl.sum_en      = (state_reg == ST_SUM);
        ctrl.coeff_index = item.coeff_index;
        ctrl.coeff_value = item.coeff_value;
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (ctrl.shift_en)
                    state_next = ST_MULT;
            end
            ST_MULT:
            begin
                cnt_next   = '0;
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                // The sum needs TAPS steps to reach the last cell.
                if (cnt_reg == LAST)
                    state_next = ST_DRAIN;
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            ST_DRAIN:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    assign x_chain[0]   = item.sample;
    assign sum_chain[0] = '0;

    for (genvar j = 0; j < TAPS; j++)
    begin : g_cell
        if (j < TAPS - 1)
        begin : g_mid
            fir_cell #(
                .ACC_W (ACC_W),
                .IDX   (j)
            ) u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .ctrl    (ctrl),
                .x_in    (x_chain[j]),
                .x_out   (x_chain[j+1]),
                .sum_in  (sum_chain[j]),
                .sum_out (sum_chain[j+1])
            );
        end
        else
        begin : g_last
            fir_cell #(
                .ACC_W (ACC_W),
                .IDX   (j)
            ) u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .ctrl    (ctrl),
                .x_in    (x_chain[j]),
                .x_out   (),
                .sum_in  (sum_chain[j]),
                .sum_out (sum_chain[j+1])
            );
        end
    end

    fir_out #(
        .ACC_W (ACC_W)
    ) u_out (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (out_load),
        .sum          (sum_chain[TAPS]),
        .free         (out_free),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    `FIR_ASSERT_NEXT(a_sample_starts_mult, ctrl.shift_en, state_reg == ST_MULT)
    `FIR_ASSERT_NEXT(a_mult_starts_sum, state_reg == ST_MULT,
                     state_reg == ST_SUM && cnt_reg == '0)
    `FIR_ASSERT_NEXT(a_sum_ends_in_drain, state_reg == ST_SUM && cnt_reg == LAST,
                     state_reg == ST_DRAIN)
    `FIR_ASSERT_NEXT(a_load_gives_result, out_load, result_valid)
    `FIR_ASSERT_SAME(a_no_coeff_while_busy, state_reg != ST_IDLE, !ctrl.coeff_we)

endmodule

@@ tb/fir_checker.sv @@
// ----------------------------------------------------------------------------
// FIR filter response checker
// Watches the item and result channels, keeps its own copy of the delay
// line and taps, predicts each filtered sample and compares it on arrival.
// ----------------------------------------------------------------------------
module fir_checker #(
    parameter int TAPS = fir_pkg::TAPS_DEFAULT
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    input  logic                 item_stall,
    input  fir_pkg::fir_item_t   item,
    input  logic                 result_valid,
    input  logic                 result_stall,
    input  fir_pkg::fir_result_t result,
    output int                   mismatches,
    output int                   results_owed
);

    logic signed [fir_pkg::SAMPLE_W-1:0] history [TAPS];
    logic signed [fir_pkg::COEFF_W-1:0]  taps [TAPS];
    int unsigned                         newest;
    fir_pkg::fir_result_t                owed_q [$];
    int                                  error_total;

    // Pushes one sample and forms floor(sum / 2^15), clipped to 16 bits.
    function automatic fir_pkg::fir_result_t filter_sample(
        input logic signed [fir_pkg::SAMPLE_W-1:0] s
    );
        longint               acc;
        longint               scaled;
        int unsigned          pos;
        fir_pkg::fir_result_t r;
        acc    = 0;
        newest = (newest + 1) % TAPS;
        history[newest] = s;
        pos = newest;
        for (int j = 0; j < TAPS; j++)
        begin
            acc += longint'(history[pos]) * longint'(taps[j]);
            pos = (pos == 0) ? TAPS - 1 : pos - 1;
        end
        scaled      = acc >>> fir_pkg::FRAC_BITS;
        r.saturated = 1'b1;
        if (scaled > 32767)
            scaled = 32767;
        else if (scaled < -32768)
            scaled = -32768;
        else
            r.saturated = 1'b0;
        r.filtered = scaled[fir_pkg::SAMPLE_W-1:0];
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        fir_pkg::fir_result_t want;
        if (!rst_n)
        begin
            for (int k = 0; k < TAPS; k++)
            begin
                history[k] = '0;
                taps[k]    = '0;
            end
            newest      = 0;
            error_total = 0;
            owed_q.delete();
            mismatches   <= 0;
            results_owed <= 0;
        end
        else
        begin
            // Results are checked before new items are taken in; a sample can
            // never produce its result at the edge where it is accepted.
            if (result_valid && !result_stall)
            begin
                if (owed_q.size() == 0)
                begin
                    error_total++;
                    if (error_total <= 10)
                        $display("%0t: unexpected result transaction: filtered=%0d saturated=%0b",
                                 $time, result.filtered, result.saturated);
                end
                else
                begin
                    want = owed_q.pop_front();
                    if (result.filtered !== want.filtered || result.saturated !== want.saturated)
                    begin
                        error_total++;
                        if (error_total <= 10)
                            $display({"%0t: filtered expected %0d got %0d, ",
                                      "saturated expected %0b got %0b"},
                                     $time, want.filtered, result.filtered,
                                     want.saturated, result.saturated);
                    end
                end
            end
            if (item_valid && !item_stall)
            begin
                if (item.mode == fir_pkg::MODE_SAMPLE)
                    owed_q.insert(owed_q.size(), filter_sample(item.sample));
                else if (item.coeff_index < TAPS)
                    taps[item.coeff_index] = item.coeff_value;
                // A load aimed past the last tap is dropped by the block.
            end
            mismatches   <= error_total;
            results_owed <= owed_q.size();
        end
    end

endmodule

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// FIR low-pass filter testbench
// Drives directed and random coefficient loads and samples through the item
// channel under varying sender and receiver idling; the checker predicts and
// compares every filtered sample and this module reports the verdict.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int TAPS = fir_pkg::TAPS_DEFAULT;
    localparam logic signed [fir_pkg::SAMPLE_W-1:0] FULL_POS = 16'sh7fff;
    localparam logic signed [fir_pkg::SAMPLE_W-1:0] FULL_NEG = 16'sh8000;

    logic                 clk          = 1'b0;
    logic                 rst_n        = 1'b0;
    logic                 item_valid   = 1'b0;
    logic                 item_stall;
    fir_pkg::fir_item_t   item         = '0;
    logic                 result_valid;
    logic                 result_stall = 1'b0;
    fir_pkg::fir_result_t result;
    int                   mismatches;
    int                   results_owed;

    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int items_sent  = 0;

    fir_lowpass_filter #(.TAPS(TAPS)) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    fir_checker #(.TAPS(TAPS)) response_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .mismatches   (mismatches),
        .results_owed (results_owed)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
        result_stall <= ($urandom_range(99, 0) < rx_idle_pct);

    // Unused fields carry random junk so the block must ignore them.
    function automatic fir_pkg::fir_item_t sample_item(
        input logic signed [fir_pkg::SAMPLE_W-1:0] s
    );
        fir_pkg::fir_item_t it;
        it.mode        = fir_pkg::MODE_SAMPLE;
        it.sample      = s;
        it.coeff_index = fir_pkg::INDEX_W'($urandom);
        it.coeff_value = fir_pkg::COEFF_W'($urandom);
        return it;
    endfunction

    function automatic fir_pkg::fir_item_t coeff_item(
        input int                                 idx,
        input logic signed [fir_pkg::COEFF_W-1:0] v
    );
        fir_pkg::fir_item_t it;
        it.mode        = fir_pkg::MODE_COEFF;
        it.sample      = fir_pkg::SAMPLE_W'($urandom);
        it.coeff_index = fir_pkg::INDEX_W'(idx);
        it.coeff_value = v;
        return it;
    endfunction

    task automatic send_item(input fir_pkg::fir_item_t it);
        while ($urandom_range(99, 0) < tx_idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= it;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic wait_drained();
        item_valid <= 1'b0;
        do
            @(posedge clk);
        while (results_owed != 0);
    endtask

    // Most passes reprogram a set of taps at one scale and then stream samples
    // at another, so that clipped and unclipped sums occur; others send one item.
    task automatic random_traffic(input int stop_at);
        int                                  n_loads;
        int                                  n_samples;
        int                                  coeff_shift;
        int                                  sample_shift;
        int                                  idx;
        bit                                  dense;
        bit                                  flush;
        logic signed [fir_pkg::COEFF_W-1:0]  v;
        logic signed [fir_pkg::SAMPLE_W-1:0] s;
        while (items_sent < stop_at)
        begin
            if ($urandom_range(9, 0) == 0)
            begin
                if ($urandom_range(1, 0) == 1)
                    send_item(coeff_item($urandom_range(fir_pkg::COEFF_SPAN - 1, 0),
                                         fir_pkg::COEFF_W'($urandom)));
                else
                    send_item(sample_item(fir_pkg::SAMPLE_W'($urandom)));
            end
            else
            begin
                coeff_shift = $urandom_range(8, 0);
                n_loads     = $urandom_range(40, 1);
                dense       = 1'($urandom_range(1, 0));
                for (int i = 0; i < n_loads; i++)
                begin
                    idx = dense ? i : $urandom_range(fir_pkg::COEFF_SPAN - 1, 0);
                    case ($urandom_range(7, 0))
                        0:       v = '0;
                        1:       v = $urandom_range(1, 0) ? FULL_POS : FULL_NEG;
                        default: v = fir_pkg::COEFF_W'($urandom) >>> coeff_shift;
                    endcase
                    send_item(coeff_item(idx, v));
                end
                n_samples    = $urandom_range(20, 4);
                sample_shift = $urandom_range(6, 0);
                flush        = ($urandom_range(7, 0) == 0);
                for (int i = 0; i < n_samples; i++)
                begin
                    s = flush ? '0 : fir_pkg::SAMPLE_W'($urandom) >>> sample_shift;
                    send_item(sample_item(s));
                end
            end
        end
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        tx_idle_pct = 35;
        rx_idle_pct <= 62;

        // Every tap is zero straight out of reset.
        send_item(sample_item(FULL_POS));
        send_item(sample_item(FULL_NEG));
        // Largest positive tap against the most negative sample.
        send_item(coeff_item(0, FULL_POS));
        send_item(sample_item(FULL_NEG));
        // Minus one times minus full scale overflows by one count.
        send_item(coeff_item(0, FULL_NEG));
        send_item(sample_item(FULL_NEG));
        send_item(sample_item(FULL_POS));
        // Three full taps against full negative samples clip low.
        send_item(coeff_item(0, FULL_POS));
        send_item(coeff_item(1, FULL_POS));
        send_item(coeff_item(2, FULL_POS));
        send_item(sample_item(FULL_NEG));
        send_item(sample_item(FULL_NEG));
        send_item(sample_item(FULL_NEG));
        // The last tap position, then tiny values that expose floor rounding.
        send_item(coeff_item(fir_pkg::COEFF_SPAN - 1, FULL_NEG));
        send_item(coeff_item(0, 16'sd1));
        send_item(coeff_item(1, 16'sd0));
        send_item(coeff_item(2, 16'sd0));
        send_item(sample_item(-16'sd1));
        send_item(sample_item(16'sd1));
        send_item(sample_item(16'sd0));

        random_traffic(520);
        wait_drained();

        tx_idle_pct = 62;
        rx_idle_pct <= 35;
        random_traffic(910);
        wait_drained();

        tx_idle_pct = 0;
        rx_idle_pct <= 0;
        random_traffic(1300);
        wait_drained();

        repeat (TAPS + 8) @(posedge clk);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin
        #(24_000_000);
        $display("Mismatches found");
        $finish;
    end

endmodule
